// File: hw/rtl/vlpc_pkg.sv
// Shared types and constants of the visible lattice point counter.
// Holds the controller command codes and the status bundle.
// No dependencies.
package vlpc_pkg;

  localparam int CUBE_W  = 17;  // cube edge length field
  localparam int CNT_W   = 49;  // visible point count field
  localparam int MERT_W  = 16;  // Mertens table entry
  localparam int MUL_A_W = 35;  // signed multiplier operand A
  localparam int MUL_B_W = 19;  // signed multiplier operand B
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int LO_W    = 25;  // low slice of the weight for the split multiply
  localparam int OP_W    = 5;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_IDLE    = 5'd0;
  localparam op_t OP_CLR     = 5'd1;
  localparam op_t OP_SV_INIT = 5'd2;
  localparam op_t OP_SV_RD   = 5'd3;
  localparam op_t OP_SV_CHK  = 5'd4;
  localparam op_t OP_PR_RD   = 5'd5;
  localparam op_t OP_PR_MUL  = 5'd6;
  localparam op_t OP_PR_WR   = 5'd7;
  localparam op_t OP_NEXT_I  = 5'd8;
  localparam op_t OP_PF_INIT = 5'd9;
  localparam op_t OP_PF_RD   = 5'd10;
  localparam op_t OP_PF_WR   = 5'd11;
  localparam op_t OP_Q_LOAD  = 5'd12;
  localparam op_t OP_DIV_Q   = 5'd13;
  localparam op_t OP_WAIT_Q  = 5'd14;
  localparam op_t OP_DIV_R   = 5'd15;
  localparam op_t OP_WAIT_R  = 5'd16;
  localparam op_t OP_M_RD    = 5'd17;
  localparam op_t OP_M_LAT   = 5'd18;
  localparam op_t OP_MUL_QQ  = 5'd19;
  localparam op_t OP_MUL_T   = 5'd20;
  localparam op_t OP_MUL_LO  = 5'd21;
  localparam op_t OP_MUL_HI  = 5'd22;
  localparam op_t OP_ACC     = 5'd23;

  typedef struct packed {
    logic clr_last;
    logic sieve_none;
    logic i_end;
    logic k_end;
    logic prod_big;
    logic k_hit;
    logic l_gt_n;
    logic div_done;
  } sts_t;

endpackage

// File: hw/rtl/vlpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vlpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AW-1:0]           waddr_i,
  input  logic [WIDTH-1:0]        wdata_i,
  input  logic [AW-1:0]           raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: hw/rtl/vlpc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// No dependencies.
module vlpc_div #(
  parameter int W = 17
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic [W-1:0] quotient_o,
  output logic         done_o
);
  localparam int CTW = $clog2(W + 1);

  logic [W-1:0]   rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [CTW-1:0] cnt_q, cnt_d;
  logic           done_q, done_d;
  logic [W:0]     shifted;
  logic [W+1:0]   trial;

  assign shifted = {rem_q, quo_q[W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
      cnt_d = CTW'(W);
    end else if (cnt_q != '0) begin
      rem_d  = trial[W+1] ? shifted[W-1:0] : trial[W-1:0];
      quo_d  = {quo_q[W-2:0], ~trial[W+1]};
      cnt_d  = cnt_q - CTW'(1);
      done_d = (cnt_q == CTW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;
endmodule

// File: hw/rtl/vlpc_dp.sv
// Datapath: sieve tables, prime list, divider, multiplier and accumulator.
// Depends on vlpc_pkg, vlpc_ram and vlpc_div.
module vlpc_dp import vlpc_pkg::*; #(
  parameter int MAX_N       = 65536,
  parameter int PRIME_SLOTS = 8192
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  op_t               op_i,
  input  logic [CUBE_W-1:0] cube_size_i,
  output sts_t              sts_o,
  output logic [CNT_W-1:0]  visible_count_o
);
  localparam int NW = $clog2(MAX_N + 1);
  localparam int CW = $clog2(PRIME_SLOTS + 1);
  localparam int PA = (PRIME_SLOTS > 1) ? $clog2(PRIME_SLOTS) : 1;
  localparam int PW = 2 * NW;
  localparam int SW = (NW > CUBE_W) ? NW : CUBE_W;
  localparam logic [NW-1:0] MAX_IDX = NW'(MAX_N);

  // sieve state
  logic [NW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            k_q, k_d, total_q, total_d, lpidx_q, lpidx_d;
  logic signed [MERT_W-1:0] mu_q, mu_d, sum_q, sum_d;
  logic [PW-1:0]            prod_q, prod_d;
  // query state
  logic [CUBE_W-1:0]        n_q, n_d, q_q, q_d, r_q, r_d;
  logic [CUBE_W:0]          l_q, l_d;
  logic signed [MERT_W-1:0] prevm_q, prevm_d;
  logic signed [MERT_W:0]   diff_q, diff_d;
  logic signed [MUL_P_W-1:0] mp_q, mp_d;
  logic [CNT_W-1:0]         t_q, t_d, acc_q, acc_d;

  // memory ports
  logic                     m_we, lp_we, p_we;
  logic [NW-1:0]            m_waddr, m_raddr, lp_waddr;
  logic signed [MERT_W-1:0] m_wdata, m_rdata;
  logic [CW-1:0]            lp_wdata, lp_rdata;
  logic [PA-1:0]            p_waddr;
  logic [NW-1:0]            p_rdata;

  logic                     div_start, div_done;
  logic [CUBE_W-1:0]        div_dvs, div_quo;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  logic                     composite, prod_big, k_hit, i_end;
  logic [SW-1:0]            n_ext, r_ext;
  logic signed [MERT_W-1:0] pf_sum;

  assign composite = (lp_rdata != '0);
  assign prod_big  = (prod_q > PW'(MAX_N));
  assign k_hit     = (k_q == lpidx_q);
  assign i_end     = (idx_q == MAX_IDX);
  assign n_ext     = SW'(cube_size_i);
  assign r_ext     = SW'(r_q);
  assign pf_sum    = sum_q + m_rdata;

  assign sts_o.clr_last   = i_end;
  assign sts_o.sieve_none = (MAX_N < 2);
  assign sts_o.i_end      = i_end;
  assign sts_o.k_end      = (k_q >= total_q);
  assign sts_o.prod_big   = prod_big;
  assign sts_o.k_hit      = k_hit;
  assign sts_o.l_gt_n     = (l_q > {1'b0, n_q});
  assign sts_o.div_done   = div_done;

  always_comb begin
    m_we     = 1'b0;
    m_waddr  = idx_q;
    m_wdata  = '0;
    m_raddr  = idx_q;
    lp_we    = 1'b0;
    lp_waddr = idx_q;
    lp_wdata = '0;
    p_we     = 1'b0;
    p_waddr  = total_q[PA-1:0];
    case (op_i)
      OP_CLR: begin
        m_we    = 1'b1;
        m_wdata = (idx_q == NW'(1)) ? MERT_W'(1) : '0;
        lp_we   = 1'b1;
      end
      OP_SV_CHK: begin
        if (!composite) begin
          m_we    = 1'b1;
          m_wdata = '1;
          p_we    = (total_q < CW'(PRIME_SLOTS));
        end
      end
      OP_PR_WR: begin
        if (!prod_big) begin
          m_we     = 1'b1;
          m_waddr  = prod_q[NW-1:0];
          m_wdata  = k_hit ? '0 : -mu_q;
          lp_we    = 1'b1;
          lp_waddr = prod_q[NW-1:0];
          lp_wdata = k_q + CW'(1);
        end
      end
      OP_PF_WR: begin
        m_we    = 1'b1;
        m_wdata = pf_sum;
      end
      OP_M_RD: m_raddr = r_ext[NW-1:0];
      default: ;
    endcase
  end

  vlpc_ram #(.WIDTH(MERT_W), .DEPTH(MAX_N + 1)) u_mert (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  // least prime factor as prime list index plus one, zero while unmarked
  vlpc_ram #(.WIDTH(CW), .DEPTH(MAX_N + 1)) u_lpf (
    .clk_i   (clk_i),
    .we_i    (lp_we),
    .waddr_i (lp_waddr),
    .wdata_i (lp_wdata),
    .raddr_i (idx_q),
    .rdata_o (lp_rdata)
  );

  vlpc_ram #(.WIDTH(NW), .DEPTH(PRIME_SLOTS)) u_prime (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (idx_q),
    .raddr_i (k_q[PA-1:0]),
    .rdata_o (p_rdata)
  );

  assign div_start = (op_i == OP_DIV_Q) || (op_i == OP_DIV_R);
  assign div_dvs   = (op_i == OP_DIV_R) ? q_q : l_q[CUBE_W-1:0];

  vlpc_div #(.W(CUBE_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q),
    .divisor_i  (div_dvs),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_i)
      OP_MUL_QQ: begin
        mul_a = $signed(MUL_A_W'(q_q));
        mul_b = $signed(MUL_B_W'(q_q));
      end
      OP_MUL_T: begin
        mul_a = $signed(MUL_A_W'(mp_q[2*CUBE_W-1:0]));
        mul_b = $signed(MUL_B_W'(q_q) + MUL_B_W'(3));
      end
      OP_MUL_LO: begin
        mul_a = $signed(MUL_A_W'(mp_q[LO_W-1:0]));
        mul_b = MUL_B_W'(diff_q);
      end
      OP_MUL_HI: begin
        mul_a = $signed(MUL_A_W'(t_q[CNT_W-1:LO_W]));
        mul_b = MUL_B_W'(diff_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    idx_d   = idx_q;
    k_d     = k_q;
    total_d = total_q;
    lpidx_d = lpidx_q;
    mu_d    = mu_q;
    sum_d   = sum_q;
    prod_d  = prod_q;
    n_d     = n_q;
    q_d     = q_q;
    r_d     = r_q;
    l_d     = l_q;
    prevm_d = prevm_q;
    diff_d  = diff_q;
    mp_d    = mp_q;
    t_d     = t_q;
    acc_d   = acc_q;
    case (op_i)
      OP_CLR: if (!i_end) idx_d = idx_q + NW'(1);
      OP_SV_INIT: begin
        idx_d   = NW'(2);
        total_d = '0;
      end
      OP_SV_CHK: begin
        k_d = '0;
        if (!composite) begin
          mu_d    = '1;
          lpidx_d = total_q;
          if (total_q < CW'(PRIME_SLOTS)) total_d = total_q + CW'(1);
        end else begin
          mu_d    = m_rdata;
          lpidx_d = lp_rdata - CW'(1);
        end
      end
      OP_PR_MUL: prod_d = PW'(idx_q) * PW'(p_rdata);
      OP_PR_WR: if (!prod_big && !k_hit) k_d = k_q + CW'(1);
      OP_NEXT_I: if (!i_end) idx_d = idx_q + NW'(1);
      OP_PF_INIT: begin
        idx_d = NW'(1);
        sum_d = '0;
      end
      OP_PF_WR: begin
        sum_d = pf_sum;
        if (!i_end) idx_d = idx_q + NW'(1);
      end
      OP_Q_LOAD: begin
        n_d     = (n_ext > SW'(MAX_N)) ? CUBE_W'(MAX_N) : cube_size_i;
        l_d     = (CUBE_W + 1)'(1);
        acc_d   = (cube_size_i == '0) ? '0 : CNT_W'(3);
        prevm_d = '0;
      end
      OP_WAIT_Q: if (div_done) q_d = div_quo;
      OP_WAIT_R: if (div_done) r_d = div_quo;
      OP_M_LAT: begin
        diff_d  = (MERT_W + 1)'(m_rdata) - (MERT_W + 1)'(prevm_q);
        prevm_d = m_rdata;
      end
      OP_MUL_QQ, OP_MUL_T: mp_d = mul_a * mul_b;
      OP_MUL_LO: begin
        t_d  = mp_q[CNT_W-1:0];
        mp_d = mul_a * mul_b;
      end
      OP_MUL_HI: begin
        acc_d = acc_q + mp_q[CNT_W-1:0];
        mp_d  = mul_a * mul_b;
      end
      OP_ACC: begin
        acc_d = acc_q + {mp_q[CNT_W-LO_W-1:0], {LO_W{1'b0}}};
        l_d   = {1'b0, r_q} + (CUBE_W + 1)'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      k_q     <= '0;
      total_q <= '0;
      l_q     <= '0;
      n_q     <= '0;
    end else begin
      idx_q   <= idx_d;
      k_q     <= k_d;
      total_q <= total_d;
      l_q     <= l_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lpidx_q <= lpidx_d;
    mu_q    <= mu_d;
    sum_q   <= sum_d;
    prod_q  <= prod_d;
    q_q     <= q_d;
    r_q     <= r_d;
    prevm_q <= prevm_d;
    diff_q  <= diff_d;
    mp_q    <= mp_d;
    t_q     <= t_d;
    acc_q   <= acc_d;
  end

  assign visible_count_o = acc_q;
endmodule

// File: hw/rtl/vlpc_ctrl.sv
// Controller state machine: sequences table clear, sieve, prefix sums and queries.
// Depends on vlpc_pkg.
module vlpc_ctrl import vlpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output op_t  op_o,
  output logic busy_o,
  output logic done_o
);
  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_SVI   = 5'd1;
  localparam logic [4:0] S_SVRD  = 5'd2;
  localparam logic [4:0] S_SVCHK = 5'd3;
  localparam logic [4:0] S_PRRD  = 5'd4;
  localparam logic [4:0] S_PRMUL = 5'd5;
  localparam logic [4:0] S_PRWR  = 5'd6;
  localparam logic [4:0] S_NEXTI = 5'd7;
  localparam logic [4:0] S_PFI   = 5'd8;
  localparam logic [4:0] S_PFRD  = 5'd9;
  localparam logic [4:0] S_PFWR  = 5'd10;
  localparam logic [4:0] S_IDLE  = 5'd11;
  localparam logic [4:0] S_LOOP  = 5'd12;
  localparam logic [4:0] S_DQ    = 5'd13;
  localparam logic [4:0] S_WQ    = 5'd14;
  localparam logic [4:0] S_DR    = 5'd15;
  localparam logic [4:0] S_WR    = 5'd16;
  localparam logic [4:0] S_MRD   = 5'd17;
  localparam logic [4:0] S_MLAT  = 5'd18;
  localparam logic [4:0] S_MQQ   = 5'd19;
  localparam logic [4:0] S_MT    = 5'd20;
  localparam logic [4:0] S_MLO   = 5'd21;
  localparam logic [4:0] S_MHI   = 5'd22;
  localparam logic [4:0] S_ACC   = 5'd23;
  localparam logic [4:0] S_RES   = 5'd24;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = OP_IDLE;
    case (state_q)
      S_CLR: begin
        op_o = OP_CLR;
        if (sts_i.clr_last) state_d = S_SVI;
      end
      S_SVI: begin
        op_o    = OP_SV_INIT;
        state_d = sts_i.sieve_none ? S_PFI : S_SVRD;
      end
      S_SVRD: begin
        op_o    = OP_SV_RD;
        state_d = S_SVCHK;
      end
      S_SVCHK: begin
        op_o    = OP_SV_CHK;
        state_d = S_PRRD;
      end
      S_PRRD: begin
        op_o    = OP_PR_RD;
        state_d = sts_i.k_end ? S_NEXTI : S_PRMUL;
      end
      S_PRMUL: begin
        op_o    = OP_PR_MUL;
        state_d = S_PRWR;
      end
      S_PRWR: begin
        op_o    = OP_PR_WR;
        state_d = (sts_i.prod_big || sts_i.k_hit) ? S_NEXTI : S_PRRD;
      end
      S_NEXTI: begin
        op_o    = OP_NEXT_I;
        state_d = sts_i.i_end ? S_PFI : S_SVRD;
      end
      S_PFI: begin
        op_o    = OP_PF_INIT;
        state_d = S_PFRD;
      end
      S_PFRD: begin
        op_o    = OP_PF_RD;
        state_d = S_PFWR;
      end
      S_PFWR: begin
        op_o    = OP_PF_WR;
        state_d = sts_i.i_end ? S_IDLE : S_PFRD;
      end
      S_IDLE: begin
        if (start_i) begin
          op_o    = OP_Q_LOAD;
          state_d = S_LOOP;
        end
      end
      S_LOOP: state_d = sts_i.l_gt_n ? S_RES : S_DQ;
      S_DQ: begin
        op_o    = OP_DIV_Q;
        state_d = S_WQ;
      end
      S_WQ: begin
        op_o = OP_WAIT_Q;
        if (sts_i.div_done) state_d = S_DR;
      end
      S_DR: begin
        op_o    = OP_DIV_R;
        state_d = S_WR;
      end
      S_WR: begin
        op_o = OP_WAIT_R;
        if (sts_i.div_done) state_d = S_MRD;
      end
      S_MRD: begin
        op_o    = OP_M_RD;
        state_d = S_MLAT;
      end
      S_MLAT: begin
        op_o    = OP_M_LAT;
        state_d = S_MQQ;
      end
      S_MQQ: begin
        op_o    = OP_MUL_QQ;
        state_d = S_MT;
      end
      S_MT: begin
        op_o    = OP_MUL_T;
        state_d = S_MLO;
      end
      S_MLO: begin
        op_o    = OP_MUL_LO;
        state_d = S_MHI;
      end
      S_MHI: begin
        op_o    = OP_MUL_HI;
        state_d = S_ACC;
      end
      S_ACC: begin
        op_o    = OP_ACC;
        state_d = S_LOOP;
      end
      S_RES: state_d = S_IDLE;
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_RES);
endmodule

// File: hw/rtl/visible_lattice_point_counter_unit.sv
// Counts lattice points of [0,n]^3, origin excluded, visible from the origin.
// Depends on vlpc_pkg, vlpc_ctrl and vlpc_dp.
// Reset: async active low; then a clearing pass over the tables, the sieve and a
// prefix pass run while busy is high. A query walks the blocks of equal floor(n/d);
// per block it divides twice, reads the Mertens table, multiplies and accumulates.
module visible_lattice_point_counter_unit import vlpc_pkg::*; #(
  parameter int MAX_N       = 65536,
  parameter int PRIME_SLOTS = 8192
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [CUBE_W-1:0] cube_size_i,
  output logic              done_o,
  output logic [CNT_W-1:0]  visible_count_o
);
  op_t  op;
  sts_t sts;

  // Sequence every step; the datapath only acts on the issued command.
  // One transaction at a time; the next is taken from the cycle after the
  // result strobe, which cannot be stalled.
  vlpc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .op_o    (op),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // Hold the tables, divider and multiply-accumulate chain.
  vlpc_dp #(
    .MAX_N       (MAX_N),
    .PRIME_SLOTS (PRIME_SLOTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .cube_size_i     (cube_size_i),
    .sts_o           (sts),
    .visible_count_o (visible_count_o)
  );
endmodule

// File: hw/rtl/vlpc_checker.sv
// Port-level checks of the visible lattice point counter.
// Depends on vlpc_pkg; bound to visible_lattice_point_counter_unit.
module vlpc_checker import vlpc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic [CUBE_W-1:0] cube_size_i,
  input logic              done_o,
  input logic [CNT_W-1:0]  visible_count_o
);
  // a result transaction only closes a running query
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result strobe while idle");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted transaction left block idle");

  a_zero_cube: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cube_size_i == '0) |-> ##2 (done_o && visible_count_o == '0))
    else $error("empty cube gave wrong result");
endmodule

bind visible_lattice_point_counter_unit vlpc_checker u_vlpc_checker (.*);
